@@ src/jacobi_pkg.sv @@
// Shared types, constants and the arctangent table of the Jacobi eigen block.
package jacobi_pkg;

   // Fixed-point constants.
   localparam logic [4:0]          ROT_CAP     = 5'd24;
   localparam logic [4:0]          LAST_STEP   = 5'd29;
   localparam logic signed [33:0]  QUARTER_PI  = 34'sd843314857;
   localparam logic signed [63:0]  CORDIC_GAIN = 64'sd652032874;
   localparam logic signed [33:0]  ONE_Q30     = 34'sd1073741824;
   localparam logic signed [31:0]  ONE_Q20     = 32'sd1048576;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_THRESH = 2'd1;

   // Update phases of one rotation.
   localparam logic [1:0] PH_COL_B = 2'd0;
   localparam logic [1:0] PH_ROW_A = 2'd1;
   localparam logic [1:0] PH_COL_V = 2'd2;

   // Multiply steps of one element pair.
   localparam logic [2:0] MK_CU = 3'd0;
   localparam logic [2:0] MK_SW = 3'd1;
   localparam logic [2:0] MK_SU = 3'd2;
   localparam logic [2:0] MK_CW = 3'd3;
   localparam logic [2:0] MK_WR = 3'd4;

   typedef struct packed {
      logic signed [31:0] a_00;
      logic signed [31:0] a_01;
      logic signed [31:0] a_02;
      logic signed [31:0] a_10;
      logic signed [31:0] a_11;
      logic signed [31:0] a_12;
      logic signed [31:0] a_20;
      logic signed [31:0] a_21;
      logic signed [31:0] a_22;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] m_col0;
      logic signed [31:0] m_col1;
      logic signed [31:0] m_col2;
      logic signed [31:0] vec_0;
      logic signed [31:0] vec_1;
      logic signed [31:0] vec_2;
      logic [4:0]         rotations_used;
      logic               last_row;
   } rsp_word_type;

   typedef struct packed {
      logic       load;
      logic       search;
      logic       setup;
      logic       norm_shift;
      logic       vec_init;
      logic       vec_step;
      logic       phi_done;
      logic       quarter_init;
      logic       rot_step;
      logic       copy_ab;
      logic       sat_a;
      logic       copy_vb;
      logic       mul_en;
      logic [4:0] step;
      logic [2:0] mul_k;
      logic [1:0] pair;
      logic [1:0] phase;
      logic [1:0] row;
   } dp_cmd_type;

   typedef struct packed {
      logic below;
      logic zero_piv;
      logic d_zero;
      logic norm_done;
   } dp_status_type;

   // atan(2^-i) in units of 2^-30 rad.
   function automatic logic signed [33:0] atan_step(input logic [4:0] i);
      logic signed [33:0] r;
      unique case (i)
         5'd0:  r = 34'sd843314857;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043837;
         5'd3:  r = 34'sd133525159;
         5'd4:  r = 34'sd67021687;
         5'd5:  r = 34'sd33543516;
         5'd6:  r = 34'sd16775851;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194283;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048576;
         5'd11: r = 34'sd524288;
         5'd12: r = 34'sd262144;
         5'd13: r = 34'sd131072;
         5'd14: r = 34'sd65536;
         5'd15: r = 34'sd32768;
         5'd16: r = 34'sd16384;
         5'd17: r = 34'sd8192;
         5'd18: r = 34'sd4096;
         5'd19: r = 34'sd2048;
         5'd20: r = 34'sd1024;
         5'd21: r = 34'sd512;
         5'd22: r = 34'sd256;
         5'd23: r = 34'sd128;
         5'd24: r = 34'sd64;
         5'd25: r = 34'sd32;
         5'd26: r = 34'sd16;
         5'd27: r = 34'sd8;
         5'd28: r = 34'sd4;
         5'd29: r = 34'sd2;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

@@ src/jacobi_dp.sv @@
// Datapath of the Jacobi eigen block: matrix registers, CORDIC and multiplier.
module jacobi_dp (
   input  logic                          clock,
   input  jacobi_pkg::dp_cmd_type        cmd,
   input  jacobi_pkg::req_word_type      req_word,
   input  logic [19:0]                   thresh,
   output jacobi_pkg::dp_status_type     status,
   output logic signed [31:0]            row_m [3],
   output logic signed [31:0]            row_v [3]
);

   logic signed [31:0] a_ff [3][3];
   logic signed [31:0] a_in [3][3];
   logic signed [31:0] v_ff [3][3];
   logic signed [31:0] v_in [3][3];
   logic signed [33:0] b_ff [3][3];
   logic signed [33:0] b_in [3][3];
   logic [1:0]  p_ff, p_in, q_ff, q_in;
   logic        below_ff, below_in, zero_piv_ff, zero_piv_in;
   logic        d_zero_ff, d_zero_in, neg_ff, neg_in, apq_neg_ff, apq_neg_in;
   logic signed [63:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic signed [33:0] c_ff, c_in, s_ff, s_in;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [37:0] resp_ff, resp_in;

   logic [31:0] mag01, mag02, mag12, pick_best;
   logic [1:0]  pick_p, pick_q;
   logic signed [31:0] app, aqq, apq;
   logic signed [32:0] diff, twice;
   logic signed [63:0] xm, sx, sy;
   logic signed [33:0] atan_i, ph_pos, ph_half;
   logic signed [33:0] u_op, w_op, coef, opnd;
   logic signed [67:0] prod;
   logic signed [37:0] rnd_acc;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      return v[32] ? (~v + 33'd1) : v;
   endfunction

   function automatic logic signed [37:0] rnd30(input logic signed [67:0] v);
      logic signed [67:0] t;
      t = v + 68'sd536870912;
      return t[67:30];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > 38'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -38'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Pivot search over the upper triangle, earliest wins ties.
   always_comb begin
      mag01 = mag32(a_ff[0][1]);
      mag02 = mag32(a_ff[0][2]);
      mag12 = mag32(a_ff[1][2]);
      pick_p = 2'd0;
      pick_q = 2'd1;
      pick_best = mag01;
      if (mag02 > pick_best) begin
         pick_p = 2'd0;
         pick_q = 2'd2;
         pick_best = mag02;
      end
      if (mag12 > pick_best) begin
         pick_p = 2'd1;
         pick_q = 2'd2;
         pick_best = mag12;
      end
   end

   // Angle operands of the chosen pivot.
   assign app   = a_ff[p_ff][p_ff];
   assign aqq   = a_ff[q_ff][q_ff];
   assign apq   = a_ff[p_ff][q_ff];
   assign diff  = {aqq[31], aqq} - {app[31], app};
   assign twice = {apq, 1'b0};

   // CORDIC shifts and angle table entry.
   assign xm      = (x_ff > y_ff) ? x_ff : y_ff;
   assign sx      = y_ff >>> cmd.step;
   assign sy      = x_ff >>> cmd.step;
   assign atan_i  = jacobi_pkg::atan_step(cmd.step);
   assign ph_pos  = z_ff[33] ? 34'sd0 : z_ff;
   assign ph_half = (ph_pos + 34'sd1) >>> 1;

   // Operand selection for the shared multiplier.
   always_comb begin
      if (cmd.phase == jacobi_pkg::PH_ROW_A) begin
         u_op = b_ff[p_ff][cmd.pair];
         w_op = b_ff[q_ff][cmd.pair];
      end else begin
         u_op = b_ff[cmd.pair][p_ff];
         w_op = b_ff[cmd.pair][q_ff];
      end
      coef = (cmd.mul_k == jacobi_pkg::MK_CU || cmd.mul_k == jacobi_pkg::MK_CW) ? c_ff : s_ff;
      opnd = (cmd.mul_k == jacobi_pkg::MK_CU || cmd.mul_k == jacobi_pkg::MK_SU) ? u_op : w_op;
   end

   assign prod    = coef * opnd;
   assign rnd_acc = rnd30(acc_ff);

   // Next-state logic for all data registers.
   always_comb begin
      a_in = a_ff;
      v_in = v_ff;
      b_in = b_ff;
      p_in = p_ff;
      q_in = q_ff;
      below_in = below_ff;
      zero_piv_in = zero_piv_ff;
      d_zero_in = d_zero_ff;
      neg_in = neg_ff;
      apq_neg_in = apq_neg_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      c_in = c_ff;
      s_in = s_ff;
      acc_in = acc_ff;
      resp_in = resp_ff;

      if (cmd.load) begin
         a_in[0][0] = req_word.a_00;
         a_in[0][1] = req_word.a_01;
         a_in[0][2] = req_word.a_02;
         a_in[1][0] = req_word.a_10;
         a_in[1][1] = req_word.a_11;
         a_in[1][2] = req_word.a_12;
         a_in[2][0] = req_word.a_20;
         a_in[2][1] = req_word.a_21;
         a_in[2][2] = req_word.a_22;
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               v_in[r][j] = (r == j) ? jacobi_pkg::ONE_Q20 : 32'sd0;
            end
         end
      end

      if (cmd.search) begin
         p_in = pick_p;
         q_in = pick_q;
         below_in = pick_best < {12'd0, thresh};
      end

      if (cmd.setup) begin
         x_in = {31'd0, mag33(diff)};
         y_in = {31'd0, mag33(twice)};
         zero_piv_in = (apq == 32'sd0);
         d_zero_in = (diff == 33'sd0);
         neg_in = apq[31] != diff[32];
         apq_neg_in = apq[31];
      end

      // Normalize so that the larger magnitude reaches 2^59.
      if (cmd.norm_shift) begin
         if (xm[63:52] == 12'd0) begin
            x_in = x_ff <<< 8;
            y_in = y_ff <<< 8;
         end else begin
            x_in = x_ff <<< 1;
            y_in = y_ff <<< 1;
         end
      end

      if (cmd.vec_init) begin
         z_in = 34'sd0;
      end

      // Vectoring step: drive y toward zero, accumulate the angle.
      if (cmd.vec_step) begin
         if (y_ff > 64'sd0) begin
            x_in = x_ff + sx;
            y_in = y_ff - sy;
            z_in = z_ff + atan_i;
         end else begin
            x_in = x_ff - sx;
            y_in = y_ff + sy;
            z_in = z_ff - atan_i;
         end
      end

      // Halve the angle and seed the rotation CORDIC.
      if (cmd.phi_done) begin
         z_in = neg_ff ? -ph_half : ph_half;
         x_in = jacobi_pkg::CORDIC_GAIN;
         y_in = 64'sd0;
      end

      if (cmd.quarter_init) begin
         z_in = apq_neg_ff ? -jacobi_pkg::QUARTER_PI : jacobi_pkg::QUARTER_PI;
         x_in = jacobi_pkg::CORDIC_GAIN;
         y_in = 64'sd0;
      end

      // Rotation step: produces cosine in x and sine in y.
      if (cmd.rot_step) begin
         if (!z_ff[33]) begin
            x_in = x_ff - sx;
            y_in = y_ff + sy;
            z_in = z_ff - atan_i;
         end else begin
            x_in = x_ff + sx;
            y_in = y_ff - sy;
            z_in = z_ff + atan_i;
         end
      end

      if (cmd.copy_ab) begin
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               b_in[r][j] = 34'(a_ff[r][j]);
            end
         end
         c_in = zero_piv_ff ? jacobi_pkg::ONE_Q30 : x_ff[33:0];
         s_in = zero_piv_ff ? 34'sd0 : y_ff[33:0];
      end

      if (cmd.sat_a) begin
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               a_in[r][j] = sat32(38'(b_ff[r][j]));
            end
         end
      end

      if (cmd.copy_vb) begin
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               b_in[r][j] = 34'(v_ff[r][j]);
            end
         end
      end

      // Two-product element updates through the shared multiplier.
      if (cmd.mul_en) begin
         unique case (cmd.mul_k)
            jacobi_pkg::MK_CU: acc_in = prod;
            jacobi_pkg::MK_SW: acc_in = acc_ff - prod;
            jacobi_pkg::MK_SU: begin
               acc_in = prod;
               resp_in = rnd_acc;
            end
            jacobi_pkg::MK_CW: acc_in = acc_ff + prod;
            default: begin
               if (cmd.phase == jacobi_pkg::PH_COL_B) begin
                  b_in[cmd.pair][p_ff] = resp_ff[33:0];
                  b_in[cmd.pair][q_ff] = rnd_acc[33:0];
               end else if (cmd.phase == jacobi_pkg::PH_ROW_A) begin
                  a_in[p_ff][cmd.pair] = sat32(resp_ff);
                  a_in[q_ff][cmd.pair] = sat32(rnd_acc);
               end else begin
                  v_in[cmd.pair][p_ff] = sat32(resp_ff);
                  v_in[cmd.pair][q_ff] = sat32(rnd_acc);
               end
            end
         endcase
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      v_ff <= v_in;
      b_ff <= b_in;
      p_ff <= p_in;
      q_ff <= q_in;
      below_ff <= below_in;
      zero_piv_ff <= zero_piv_in;
      d_zero_ff <= d_zero_in;
      neg_ff <= neg_in;
      apq_neg_ff <= apq_neg_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      c_ff <= c_in;
      s_ff <= s_in;
      acc_ff <= acc_in;
      resp_ff <= resp_in;
   end

   // Status to the controller and the selected output row.
   assign status.below     = below_ff;
   assign status.zero_piv  = zero_piv_ff;
   assign status.d_zero    = d_zero_ff;
   assign status.norm_done = xm[63:59] != 5'd0;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         row_m[j] = a_ff[cmd.row][j];
         row_v[j] = v_ff[cmd.row][j];
      end
   end

endmodule

@@ src/jacobi_ctrl.sv @@
// Controller state machine that sequences the Jacobi rotations.
module jacobi_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_fire,
   input  logic                       rsp_stall,
   input  logic [4:0]                 limit,
   input  jacobi_pkg::dp_status_type  status,
   output jacobi_pkg::dp_cmd_type     cmd,
   output logic [4:0]                 used,
   output logic                       rsp_valid,
   output logic                       req_stall
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SEARCH = 4'd1;
   localparam logic [3:0] S_SETUP  = 4'd2;
   localparam logic [3:0] S_NORM   = 4'd3;
   localparam logic [3:0] S_VEC    = 4'd4;
   localparam logic [3:0] S_PHI    = 4'd5;
   localparam logic [3:0] S_ROT    = 4'd6;
   localparam logic [3:0] S_COPY   = 4'd7;
   localparam logic [3:0] S_MUL    = 4'd8;
   localparam logic [3:0] S_SATA   = 4'd9;
   localparam logic [3:0] S_COPYV  = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [4:0] step_ff, step_in, used_ff, used_in;
   logic [2:0] k_ff, k_in;
   logic [1:0] pair_ff, pair_in, phase_ff, phase_in, row_ff, row_in;
   logic [4:0] lim;

   assign lim = (limit > jacobi_pkg::ROT_CAP) ? jacobi_pkg::ROT_CAP : limit;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      used_in = used_ff;
      k_in = k_ff;
      pair_in = pair_ff;
      phase_in = phase_ff;
      row_in = row_ff;
      cmd = '0;
      cmd.step = step_ff;
      cmd.mul_k = k_ff;
      cmd.pair = pair_ff;
      cmd.phase = phase_ff;
      cmd.row = row_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               used_in = 5'd0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (used_ff >= lim) begin
               row_in = 2'd0;
               state_in = S_OUT;
            end else begin
               cmd.search = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (status.below) begin
               row_in = 2'd0;
               state_in = S_OUT;
            end else begin
               cmd.setup = 1'b1;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            step_in = 5'd0;
            if (status.zero_piv) begin
               state_in = S_COPY;
            end else if (status.d_zero) begin
               cmd.quarter_init = 1'b1;
               state_in = S_ROT;
            end else if (status.norm_done) begin
               cmd.vec_init = 1'b1;
               state_in = S_VEC;
            end else begin
               cmd.norm_shift = 1'b1;
            end
         end
         S_VEC: begin
            cmd.vec_step = 1'b1;
            step_in = step_ff + 5'd1;
            if (step_ff == jacobi_pkg::LAST_STEP) begin
               state_in = S_PHI;
            end
         end
         S_PHI: begin
            cmd.phi_done = 1'b1;
            step_in = 5'd0;
            state_in = S_ROT;
         end
         S_ROT: begin
            cmd.rot_step = 1'b1;
            step_in = step_ff + 5'd1;
            if (step_ff == jacobi_pkg::LAST_STEP) begin
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            cmd.copy_ab = 1'b1;
            phase_in = jacobi_pkg::PH_COL_B;
            pair_in = 2'd0;
            k_in = jacobi_pkg::MK_CU;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            k_in = k_ff + 3'd1;
            if (k_ff == jacobi_pkg::MK_WR) begin
               k_in = jacobi_pkg::MK_CU;
               pair_in = pair_ff + 2'd1;
               if (pair_ff == 2'd2) begin
                  pair_in = 2'd0;
                  if (phase_ff == jacobi_pkg::PH_COL_B) begin
                     state_in = S_SATA;
                  end else if (phase_ff == jacobi_pkg::PH_ROW_A) begin
                     state_in = S_COPYV;
                  end else begin
                     used_in = used_ff + 5'd1;
                     state_in = S_SEARCH;
                  end
               end
            end
         end
         S_SATA: begin
            cmd.sat_a = 1'b1;
            phase_in = jacobi_pkg::PH_ROW_A;
            state_in = S_MUL;
         end
         S_COPYV: begin
            cmd.copy_vb = 1'b1;
            phase_in = jacobi_pkg::PH_COL_V;
            state_in = S_MUL;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               row_in = row_ff + 2'd1;
               if (row_ff == 2'd2) begin
                  row_in = 2'd0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= 5'd0;
         used_ff <= 5'd0;
         k_ff <= jacobi_pkg::MK_CU;
         pair_ff <= 2'd0;
         phase_ff <= jacobi_pkg::PH_COL_B;
         row_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         used_ff <= used_in;
         k_ff <= k_in;
         pair_ff <= pair_in;
         phase_ff <= phase_in;
         row_ff <= row_in;
      end
   end

   assign used      = used_ff;
   assign rsp_valid = state_ff == S_OUT;
   assign req_stall = state_ff != S_IDLE;

endmodule

@@ src/jacobi_eigen_3x3.sv @@
// Top level of the 3x3 Jacobi eigenvalue block.
//
// A matrix word (nine signed Q12.20 elements, row-major) enters on the req_
// channel whenever req_stall is low. The block then works on it alone, with
// req_stall high, until its three result words have been taken.
// Each rotation is a pivot search, normalization, 30 vectoring and 30 rotation
// CORDIC steps (skipped for a zero pivot), and element updates through the one
// shared multiplier (9 element pairs). A matrix takes at most the full 24
// rotations; a matrix that needs none goes straight to its first result word.
// Results come out as three words on the rsp_ channel, row 0 to row 2, each
// holding one row of the rotated matrix and one row of the eigenvector matrix;
// last_row marks the third. While rsp_stall is high the current word holds.
// The csr_ port writes the rotation limit and stop threshold. Users must make
// writes while the block is idle (unchecked). Reset: idle, limit 24, thresh 1.
module jacobi_eigen_3x3 (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  jacobi_pkg::req_word_type  req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output jacobi_pkg::rsp_word_type  rsp_word,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_index,
   input  logic [19:0]               csr_wdata
);

   logic [4:0]  limit_ff, limit_in;
   logic [19:0] thresh_ff, thresh_in;
   logic        req_fire;
   logic [4:0]  used;
   jacobi_pkg::dp_cmd_type    cmd;
   jacobi_pkg::dp_status_type status;
   logic signed [31:0] row_m [3];
   logic signed [31:0] row_v [3];

   // Configuration registers.
   always_comb begin
      limit_in = limit_ff;
      thresh_in = thresh_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            jacobi_pkg::CSR_LIMIT:  limit_in = csr_wdata[4:0];
            jacobi_pkg::CSR_THRESH: thresh_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= jacobi_pkg::ROT_CAP;
         thresh_ff <= 20'd1;
      end else begin
         limit_ff <= limit_in;
         thresh_ff <= thresh_in;
      end
   end

   assign req_fire = req_valid && !req_stall;

   jacobi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rsp_stall (rsp_stall),
      .limit     (limit_ff),
      .status    (status),
      .cmd       (cmd),
      .used      (used),
      .rsp_valid (rsp_valid),
      .req_stall (req_stall)
   );

   jacobi_dp u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .req_word (req_word),
      .thresh   (thresh_ff),
      .status   (status),
      .row_m    (row_m),
      .row_v    (row_v)
   );

   // Result word.
   assign rsp_word.row_index      = cmd.row;
   assign rsp_word.m_col0         = row_m[0];
   assign rsp_word.m_col1         = row_m[1];
   assign rsp_word.m_col2         = row_m[2];
   assign rsp_word.vec_0          = row_v[0];
   assign rsp_word.vec_1          = row_v[1];
   assign rsp_word.vec_2          = row_v[2];
   assign rsp_word.rotations_used = used;
   assign rsp_word.last_row       = cmd.row == 2'd2;

`ifndef NO_ASSERTIONS
   // An accepted matrix blocks further input until its results are out.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> req_stall) else $error("input taken while busy");

   // The rotation count never passes the cap.
   a_used_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.rotations_used <= jacobi_pkg::ROT_CAP))
      else $error("rotation count above cap");

   // The last-row flag marks exactly the third row.
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.last_row == (rsp_word.row_index == 2'd2)))
      else $error("last row flag mismatch");

   // Taking the last row returns the block to idle.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_word.last_row) |=> !req_stall)
      else $error("not idle after last row");
`endif

endmodule
